### hw/rtl/binary_semaphore_priority_wait_queue_assert.svh
// Assertion macros of the semaphore wait queue controller.
`ifndef BINARY_SEMAPHORE_PRIORITY_WAIT_QUEUE_ASSERT_SVH
`define BINARY_SEMAPHORE_PRIORITY_WAIT_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bsq_pkg.sv
// Types, constants and helper functions of the semaphore wait queue.
`timescale 1ns / 1ps
package bsq_pkg;

  localparam int MAX_WAITERS_DEF = 8;
  localparam int TASK_COUNT      = 32;
  localparam int PRIORITY_LEVELS = 32;

  localparam int ID_W   = 5;
  localparam int PRIO_W = 5;
  localparam int PRIO_MAX = PRIORITY_LEVELS - 1;

  typedef enum logic [1:0] {
    MODE_TAKE   = 2'd0,
    MODE_GIVE   = 2'd1,
    MODE_REMOVE = 2'd2
  } bsq_mode_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NOWAIT   = 3'd1,
    STS_QUEUED   = 3'd2,
    STS_FULL     = 3'd3,
    STS_ALREADY  = 3'd4,
    STS_NOTFOUND = 3'd5
  } bsq_status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_POP
  } bsq_cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } bsq_state_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic               cap;
    bsq_cell_op_t       op;
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  prio;
  } bsq_bcast_t;

  // Task id reduced modulo the task count, as a small constant table.
  function automatic logic [ID_W-1:0] reduce_task(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] res;
    res = '0;
    for (int k = 0; k < (1 << ID_W); k++) begin
      if (id == ID_W'(k)) begin
        res = ID_W'(k % TASK_COUNT);
      end
    end
    return res;
  endfunction

  // Priority saturated to the most relaxed level.
  function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] res;
    res = p;
    if (9'(p) > 9'(PRIO_MAX)) begin
      res = PRIO_W'(PRIO_MAX);
    end
    return res;
  endfunction

endpackage

### hw/rtl/bsq_cell.sv
// One slot of the sorted wait queue, shifting entries with its neighbors.
`timescale 1ns / 1ps
module bsq_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  bsq_pkg::bsq_bcast_t        bcast,
  input  logic                       hit_in,
  input  logic                       l_le,
  input  logic                       l_occ,
  input  logic [bsq_pkg::ID_W-1:0]   l_id,
  input  logic [bsq_pkg::PRIO_W-1:0] l_prio,
  input  logic                       r_occ,
  input  logic [bsq_pkg::ID_W-1:0]   r_id,
  input  logic [bsq_pkg::PRIO_W-1:0] r_prio,
  output logic                       cell_occ,
  output logic [bsq_pkg::ID_W-1:0]   cell_id,
  output logic [bsq_pkg::PRIO_W-1:0] cell_prio,
  output logic                       cell_le,
  output logic                       hit_out
);
  import bsq_pkg::*;

  logic              occ_r, occ_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              match_r, match_nxt;
  logic              le_r, le_nxt;
  logic              hit;

  // A hit anywhere up to and including this slot means this slot pulls from the right.
  assign hit = hit_in | match_r;

  always_comb begin
    occ_nxt   = occ_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    match_nxt = match_r;
    le_nxt    = le_r;
    if (bcast.cap) begin
      match_nxt = occ_r && (id_r == bcast.task_id);
      le_nxt    = occ_r && (prio_r <= bcast.prio);
    end
    unique case (bcast.op)
      OP_NONE: begin
      end
      OP_INSERT: begin
        if (!le_r) begin
          if (l_le) begin
            occ_nxt  = 1'b1;
            id_nxt   = bcast.task_id;
            prio_nxt = bcast.prio;
          end else begin
            occ_nxt  = l_occ;
            id_nxt   = l_id;
            prio_nxt = l_prio;
          end
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          occ_nxt  = r_occ;
          id_nxt   = r_id;
          prio_nxt = r_prio;
        end
      end
      OP_POP: begin
        occ_nxt  = r_occ;
        id_nxt   = r_id;
        prio_nxt = r_prio;
      end
    endcase
    if (clear) begin
      occ_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      match_r <= 1'b0;
      le_r    <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      match_r <= match_nxt;
      le_r    <= le_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  assign cell_occ  = occ_r;
  assign cell_id   = id_r;
  assign cell_prio = prio_r;
  assign cell_le   = le_r;
  assign hit_out   = hit;

endmodule

### hw/rtl/bsq_ctrl.sv
// Sequencer of the semaphore: token, waiter count, decisions and result register.
`timescale 1ns / 1ps
`include "binary_semaphore_priority_wait_queue_assert.svh"
module bsq_ctrl #(
  parameter int MAX_WAITERS = bsq_pkg::MAX_WAITERS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [15:0]              in_tdata,
  input  logic [1:0]               in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_data,
  output bsq_pkg::bsq_bcast_t      bcast,
  output logic                     clear,
  input  logic                     found,
  input  logic [bsq_pkg::ID_W-1:0] head_id
);
  import bsq_pkg::*;

  localparam int CW = $clog2(MAX_WAITERS + 1);

  bsq_state_t        state_r, state_nxt;
  logic              token_r, token_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  bsq_mode_t         mode_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  logic              may_wait_r;

  bsq_status_t       sts_r;
  logic              wv_r;
  logic [ID_W-1:0]   wt_r;
  logic              tf_r;
  logic [3:0]        wtot_r;

  logic              accept;
  logic              commit;
  logic              cfg_wr;
  bsq_cell_op_t      op_sel;
  bsq_status_t       sts_sel;
  logic              wv_sel;
  logic [ID_W-1:0]   wt_sel;
  logic              tok_sel;
  logic [CW-1:0]     cnt_sel;
  logic [ID_W-1:0]   in_id;
  logic [PRIO_W-1:0] in_prio;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign clear     = cfg_wr;
  assign in_id     = reduce_task(in_tdata[4:0]);
  assign in_prio   = sat_prio(in_tdata[9:5]);

  // Decision for the item held in the command registers.
  always_comb begin
    op_sel  = OP_NONE;
    sts_sel = STS_OK;
    wv_sel  = 1'b0;
    wt_sel  = '0;
    tok_sel = token_r;
    cnt_sel = cnt_r;
    unique case (mode_r)
      MODE_TAKE: begin
        priority if (token_r) begin
          tok_sel = 1'b0;
        end else if (!may_wait_r) begin
          sts_sel = STS_NOWAIT;
        end else if (found) begin
          sts_sel = STS_ALREADY;
        end else if (cnt_r == CW'(MAX_WAITERS)) begin
          sts_sel = STS_FULL;
        end else begin
          op_sel  = OP_INSERT;
          sts_sel = STS_QUEUED;
          cnt_sel = CW'(cnt_r + 1'b1);
        end
      end
      MODE_GIVE: begin
        if (cnt_r != '0) begin
          op_sel  = OP_POP;
          wv_sel  = 1'b1;
          wt_sel  = head_id;
          tok_sel = 1'b0;
          cnt_sel = CW'(cnt_r - 1'b1);
        end else begin
          tok_sel = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (found) begin
          op_sel  = OP_REMOVE;
          cnt_sel = CW'(cnt_r - 1'b1);
        end else begin
          sts_sel = STS_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state and handshake outputs.
  always_comb begin
    state_nxt     = state_r;
    token_nxt     = token_r;
    cnt_nxt       = cnt_r;
    in_tready     = 1'b0;
    accept        = 1'b0;
    commit        = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    bcast.cap     = 1'b0;
    bcast.op      = OP_NONE;
    bcast.task_id = id_r;
    bcast.prio    = prio_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        accept        = in_tvalid;
        bcast.cap     = in_tvalid;
        bcast.task_id = in_id;
        bcast.prio    = in_prio;
        if (in_tvalid) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        // The result register must be free before the queue is changed.
        if (!out_valid_r || out_tready) begin
          commit        = 1'b1;
          bcast.op      = op_sel;
          token_nxt     = tok_sel;
          cnt_nxt       = cnt_sel;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
    if (cfg_wr) begin
      token_nxt = cfg_data;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      token_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      token_r     <= token_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= bsq_mode_t'(in_tuser);
      id_r       <= in_id;
      prio_r     <= in_prio;
      may_wait_r <= in_tdata[10];
    end
    if (commit) begin
      sts_r  <= sts_sel;
      wv_r   <= wv_sel;
      wt_r   <= wt_sel;
      tf_r   <= tok_sel;
      wtot_r <= 4'(cnt_sel);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, wtot_r, tf_r, wt_r, wv_r, sts_r};

  `BSQ_ASSERT_NOW(a_token_no_waiters, token_r, cnt_r == '0, "token free while tasks wait")
  `BSQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_WAITERS), "waiter count over depth")
  `BSQ_ASSERT_NOW(a_woken_holds_token, out_valid_r && wv_r, !tf_r, "woken task left token free")
  `BSQ_ASSERT_NEXT(a_queued_grows, commit && sts_sel == STS_QUEUED && !cfg_wr, cnt_r == CW'($past(cnt_r) + 1'b1), "queued item did not grow the count")

endmodule

### hw/rtl/binary_semaphore_priority_wait_queue.sv
// Binary semaphore with a priority-sorted wait queue.
// Usage:
// Items enter on the in_ stream: in_tuser carries the operation (take, give,
// remove) and in_tdata the task id, its priority and the may-wait flag.
// Each item yields exactly one result beat on the out_ stream with a status,
// the woken task of a give, the token state and the number of waiters.
// The wait queue is a chain of cells, one per waiter slot, kept sorted by
// priority with first-come order among equals; inserts and removals shift
// entries between neighboring cells.
// Flow: the beat is accepted and the cells compare it against their entries
// as it is registered; in S_APPLY the chain shifts and the result is
// registered once the output register is free. No new item is taken until
// then, so in_tready stays low while an item waits in S_APPLY.
// When the receiver stalls, one finished result waits in the output register
// while the next item is accepted; that item then holds before the shift
// until the output register is free.
// Reset empties the queue and takes the token. A cfg_ beat makes the same clear and
// loads the token from cfg_data; the user must issue it only when idle (not enforced).
`timescale 1ns / 1ps
module binary_semaphore_priority_wait_queue #(
  parameter int MAX_WAITERS = bsq_pkg::MAX_WAITERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // task_id[4:0], task_priority[9:5], may_wait[10], zeros
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[2:0], woken_valid[3], woken_task[8:4],
                                  // token_free[9], waiter_total[13:10], zeros
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // initial_available
);
  import bsq_pkg::*;

  bsq_bcast_t        bcast;
  logic              clear;
  logic              occ_w  [MAX_WAITERS];
  logic [ID_W-1:0]   id_w   [MAX_WAITERS];
  logic [PRIO_W-1:0] prio_w [MAX_WAITERS];
  logic              le_w   [MAX_WAITERS];
  logic              hit_w  [MAX_WAITERS+1];

  assign hit_w[0] = 1'b0;

  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    logic              l_le, l_occ, r_occ;
    logic [ID_W-1:0]   l_id, r_id;
    logic [PRIO_W-1:0] l_prio, r_prio;

    if (i == 0) begin : g_head
      assign l_le   = 1'b1;
      assign l_occ  = 1'b0;
      assign l_id   = '0;
      assign l_prio = '0;
    end else begin : g_left
      assign l_le   = le_w[i-1];
      assign l_occ  = occ_w[i-1];
      assign l_id   = id_w[i-1];
      assign l_prio = prio_w[i-1];
    end

    if (i == MAX_WAITERS - 1) begin : g_tail
      assign r_occ  = 1'b0;
      assign r_id   = '0;
      assign r_prio = '0;
    end else begin : g_right
      assign r_occ  = occ_w[i+1];
      assign r_id   = id_w[i+1];
      assign r_prio = prio_w[i+1];
    end

    bsq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clear),
      .bcast     (bcast),
      .hit_in    (hit_w[i]),
      .l_le      (l_le),
      .l_occ     (l_occ),
      .l_id      (l_id),
      .l_prio    (l_prio),
      .r_occ     (r_occ),
      .r_id      (r_id),
      .r_prio    (r_prio),
      .cell_occ  (occ_w[i]),
      .cell_id   (id_w[i]),
      .cell_prio (prio_w[i]),
      .cell_le   (le_w[i]),
      .hit_out   (hit_w[i+1])
    );
  end

  bsq_ctrl #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .bcast      (bcast),
    .clear      (clear),
    .found      (hit_w[MAX_WAITERS]),
    .head_id    (id_w[0])
  );

endmodule
